@@ rtl/active_expired_priority_run_queue_core_defines.svh @@
// assertion macros used by the run queue checker
`ifndef ACTIVE_EXPIRED_PRIORITY_RUN_QUEUE_CORE_DEFINES_SVH
`define ACTIVE_EXPIRED_PRIORITY_RUN_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define AEPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define AEPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/aepq_pkg.sv @@
// types and constants of the active/expired priority run queue
`default_nettype none
package aepq_pkg;

	localparam int TASK_W    = 8;
	localparam int PRIO_W    = 4;
	localparam int STATUS_W  = 2;
	localparam int OUT_LVL_W = 3;
	localparam int CFG_W     = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_GET = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY        = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL         = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

	typedef struct packed {
		logic take;
		logic run;
		logic fin;
	} ctl_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/aepq_cmd_if.sv @@
// command channel: add or get beats
`default_nettype none
interface aepq_cmd_if import aepq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [TASK_W-1:0]        task_id;
	logic signed [PRIO_W-1:0] dyn_prio;
	logic [PRIO_W-1:0]        static_prio;

	modport source (output valid, action, task_id, dyn_prio, static_prio, input ready);
	modport sink (input valid, action, task_id, dyn_prio, static_prio, output ready);
endinterface
`default_nettype wire

@@ rtl/aepq_res_if.sv @@
// result channel: one beat per command
`default_nettype none
interface aepq_res_if import aepq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [TASK_W-1:0]    out_task;
	logic [OUT_LVL_W-1:0] out_level;
	logic                 went_expired;
	logic                 banks_swapped;

	modport source (output valid, status, out_task, out_level, went_expired, banks_swapped,
		input ready);
	modport sink (input valid, status, out_task, out_level, went_expired, banks_swapped,
		output ready);
endinterface
`default_nettype wire

@@ rtl/aepq_cfg_if.sv @@
// configuration write channel for the level count register
`default_nettype none
interface aepq_cfg_if import aepq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] levels_in_use;

	modport source (output valid, levels_in_use, input ready);
	modport sink (input valid, levels_in_use, output ready);
endinterface
`default_nettype wire

@@ rtl/aepq_ctrl.sv @@
// sequencer: accept, execute, load result
`default_nettype none
module aepq_ctrl import aepq_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.run = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					ctl.fin  = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						ctl.take = 1'b1;
						state_d  = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/aepq_datapath.sv @@
// queue storage, pointers, level scan and result register
`default_nettype none
module aepq_datapath import aepq_pkg::*; #(
	parameter int LEVELS      = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  ctl_t                      ctl,
	output sts_t                      sts,
	input  wire                       cfg_we,
	input  wire [CFG_W-1:0]           cfg_data,
	input  wire                       in_action,
	input  wire [TASK_W-1:0]          in_task_id,
	input  wire signed [PRIO_W-1:0]   in_dyn_prio,
	input  wire [PRIO_W-1:0]          in_static_prio,
	output logic                      res_valid,
	input  wire                       res_ready,
	output logic [STATUS_W-1:0]       res_status,
	output logic [TASK_W-1:0]         res_out_task,
	output logic [OUT_LVL_W-1:0]      res_out_level,
	output logic                      res_went_expired,
	output logic                      res_banks_swapped
);

	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int NUM_W = $clog2(LEVELS + 1);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CFG_W-1:0]         cfg_q;
	logic                     bank_q;
	logic                     act_q;
	logic [TASK_W-1:0]        tid_q;
	logic [PRIO_W-1:0]        dyn_q;
	logic [PRIO_W-1:0]        sp_q;

	logic [PTR_W-1:0]         head_q [2][LEVELS];
	logic [PTR_W-1:0]         tail_q [2][LEVELS];
	logic [CNT_W-1:0]         cnt_q  [2][LEVELS];
	logic [TASK_W-1:0]        mem_q  [2][LEVELS][QUEUE_DEPTH];
	logic [TASK_W-1:0]        rd_q;

	logic [STATUS_W-1:0]      st_q;
	logic [OUT_LVL_W-1:0]     lvl_q;
	logic                     exp_q;
	logic                     swp_q;
	logic                     use_rd_q;
	logic                     echo_q;

	logic                     res_valid_q;
	logic [STATUS_W-1:0]      res_status_q;
	logic [TASK_W-1:0]        res_task_q;
	logic [OUT_LVL_W-1:0]     res_level_q;
	logic                     res_exp_q;
	logic                     res_swp_q;

	logic [NUM_W-1:0]         eff_n;
	logic [LEVELS-1:0]        lvl_mask;
	logic [LEVELS-1:0]        ne_act;
	logic [LEVELS-1:0]        ne_oth;
	logic [LVL_W-1:0]         enc_act;
	logic [LVL_W-1:0]         enc_oth;
	logic                     any_act;
	logic                     any_oth;
	logic                     pop_bank;
	logic [LVL_W-1:0]         pop_lvl;
	logic                     do_pop;

	logic                     neg;
	logic                     add_ok;
	logic [PRIO_W-1:0]        add_lvl4;
	logic [LVL_W-1:0]         add_lvl;
	logic                     add_bank;
	logic                     add_full;
	logic                     do_push;

	// effective level count
	always_comb begin
		if (cfg_q == '0) begin
			eff_n = NUM_W'(1);
		end else if (32'(cfg_q) > 32'(LEVELS)) begin
			eff_n = NUM_W'(LEVELS);
		end else begin
			eff_n = NUM_W'(cfg_q);
		end
	end

	// level scan over both banks
	always_comb begin
		enc_act = '0;
		enc_oth = '0;
		for (int i = 0; i < LEVELS; i++) begin
			lvl_mask[i] = (i < int'(eff_n));
			ne_act[i]   = lvl_mask[i] && (cnt_q[bank_q][i] != '0);
			ne_oth[i]   = lvl_mask[i] && (cnt_q[~bank_q][i] != '0);
			if (ne_act[i]) begin
				enc_act = LVL_W'(i);
			end
			if (ne_oth[i]) begin
				enc_oth = LVL_W'(i);
			end
		end
		any_act  = |ne_act;
		any_oth  = |ne_oth;
		pop_bank = any_act ? bank_q : ~bank_q;
		pop_lvl  = any_act ? enc_act : enc_oth;
		do_pop   = ctl.run && (act_q == ACT_GET) && (any_act || any_oth);
	end

	// add target
	always_comb begin
		neg      = dyn_q[PRIO_W-1];
		add_lvl4 = neg ? (sp_q - PRIO_W'(1)) : {1'b0, dyn_q[PRIO_W-2:0]};
		if (neg) begin
			add_ok = (sp_q != '0) && (32'(sp_q) <= 32'(eff_n));
		end else begin
			add_ok = 32'(dyn_q[PRIO_W-2:0]) < 32'(eff_n);
		end
		add_lvl  = LVL_W'(add_lvl4);
		add_bank = neg ? ~bank_q : bank_q;
		add_full = add_ok && (cnt_q[add_bank][add_lvl] == CNT_W'(QUEUE_DEPTH));
		do_push  = ctl.run && (act_q == ACT_ADD) && add_ok && !add_full;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[add_bank][add_lvl][tail_q[add_bank][add_lvl]] <= tid_q;
		end
		if (do_pop) begin
			rd_q <= mem_q[pop_bank][pop_lvl][head_q[pop_bank][pop_lvl]];
		end
	end

	// input beat, step results
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			act_q <= in_action;
			tid_q <= in_task_id;
			dyn_q <= in_dyn_prio;
			sp_q  <= in_static_prio;
		end
		if (ctl.run) begin
			use_rd_q <= do_pop;
			echo_q   <= (act_q == ACT_ADD);
			if (act_q == ACT_ADD) begin
				swp_q <= 1'b0;
				if (!add_ok) begin
					st_q  <= ST_OUT_OF_RANGE;
					lvl_q <= '0;
					exp_q <= 1'b0;
				end else begin
					st_q  <= add_full ? ST_FULL : ST_OK;
					lvl_q <= OUT_LVL_W'(add_lvl4);
					exp_q <= neg;
				end
			end else begin
				exp_q <= 1'b0;
				swp_q <= !any_act;
				st_q  <= (any_act || any_oth) ? ST_OK : ST_EMPTY;
				lvl_q <= (any_act || any_oth) ? OUT_LVL_W'(pop_lvl) : '0;
			end
		end
	end

	// pointers, counts, bank select, level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q  <= CFG_RESET;
			bank_q <= 1'b0;
			for (int b = 0; b < 2; b++) begin
				for (int l = 0; l < LEVELS; l++) begin
					head_q[b][l] <= '0;
					tail_q[b][l] <= '0;
					cnt_q[b][l]  <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (do_push) begin
				tail_q[add_bank][add_lvl] <=
					(tail_q[add_bank][add_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					tail_q[add_bank][add_lvl] + PTR_W'(1);
				cnt_q[add_bank][add_lvl] <= cnt_q[add_bank][add_lvl] + CNT_W'(1);
			end
			if (do_pop) begin
				head_q[pop_bank][pop_lvl] <=
					(head_q[pop_bank][pop_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					head_q[pop_bank][pop_lvl] + PTR_W'(1);
				cnt_q[pop_bank][pop_lvl] <= cnt_q[pop_bank][pop_lvl] - CNT_W'(1);
			end
			if (ctl.run && (act_q == ACT_GET) && !any_act) begin
				bank_q <= ~bank_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			res_status_q <= st_q;
			res_level_q  <= lvl_q;
			res_exp_q    <= exp_q;
			res_swp_q    <= swp_q;
			if (echo_q) begin
				res_task_q <= tid_q;
			end else if (use_rd_q) begin
				res_task_q <= rd_q;
			end else begin
				res_task_q <= '0;
			end
		end
	end

	assign sts.out_free      = !res_valid_q || res_ready;
	assign res_valid         = res_valid_q;
	assign res_status        = res_status_q;
	assign res_out_task      = res_task_q;
	assign res_out_level     = res_level_q;
	assign res_went_expired  = res_exp_q;
	assign res_banks_swapped = res_swp_q;

endmodule
`default_nettype wire

@@ rtl/active_expired_priority_run_queue_core.sv @@
// Active/expired priority run queue: add and get commands in, one result beat out.
// cmd channel: a beat is an add (action 0) or a get (action 1). An add puts task_id
//   in the active bank at dyn_prio, or, when dyn_prio is negative, in the expired
//   bank at static_prio - 1. A get pops the highest non-empty active level, or,
//   if that bank is empty, the highest non-empty expired level and swaps the banks.
// res channel: exactly one beat per cmd beat, in order.
// cfg channel: writes levels_in_use, always ready; write only while no command is
//   in flight.
// Sequence: a cmd beat is registered when taken, executed in S_EXEC and loaded into
//   the result register in S_FIN. A new command is taken only in S_IDLE or in the
//   cycle that loads the previous result, not while one is executing in S_EXEC;
//   the queue memory is used in S_EXEC only.
// A stalled res channel holds its beat; one more command is accepted and then
//   waits finished until the result register frees.
// Reset empties all queues, makes bank zero active and sets levels_in_use to 4.
`default_nettype none
module active_expired_priority_run_queue_core import aepq_pkg::*; #(
	parameter int LEVELS      = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input wire         clk,
	input wire         arst_n,
	aepq_cmd_if.sink   cmd,
	aepq_res_if.source res,
	aepq_cfg_if.sink   cfg
);

	ctl_t ctl;
	sts_t sts;

	assign cfg.ready = 1'b1;

	aepq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	aepq_datapath #(
		.LEVELS      (LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.sts               (sts),
		.cfg_we            (cfg.valid),
		.cfg_data          (cfg.levels_in_use),
		.in_action         (cmd.action),
		.in_task_id        (cmd.task_id),
		.in_dyn_prio       (cmd.dyn_prio),
		.in_static_prio    (cmd.static_prio),
		.res_valid         (res.valid),
		.res_ready         (res.ready),
		.res_status        (res.status),
		.res_out_task      (res.out_task),
		.res_out_level     (res.out_level),
		.res_went_expired  (res.went_expired),
		.res_banks_swapped (res.banks_swapped)
	);

endmodule
`default_nettype wire

@@ rtl/aepq_checker.sv @@
// port-level checks of the run queue, bound to the top level
`default_nettype none
`include "active_expired_priority_run_queue_core_defines.svh"
module aepq_checker import aepq_pkg::*; (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 cmd_valid,
	input wire                 cmd_ready,
	input wire                 res_valid,
	input wire                 res_ready,
	input wire [STATUS_W-1:0]  res_status,
	input wire [TASK_W-1:0]    res_out_task,
	input wire [OUT_LVL_W-1:0] res_out_level,
	input wire                 res_went_expired,
	input wire                 res_banks_swapped
);

	// a stalled result beat holds
	`AEPQ_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_out_task) && $stable(res_out_level), "result beat changed while stalled")

	// a taken command is worked on before the next one is taken
	`AEPQ_ASSERT_NXT(a_one_in_flight, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready, "command taken in back-to-back cycles")

	// an empty get always reports a swap and no task
	`AEPQ_ASSERT_IMP(a_empty_get, clk, arst_n, res_valid && (res_status == ST_EMPTY), res_banks_swapped && (res_out_task == '0) && (res_out_level == '0), "empty get fields wrong")

	// adds never swap, gets never expire
	`AEPQ_ASSERT_IMP(a_exp_swp, clk, arst_n, res_valid, !(res_went_expired && res_banks_swapped), "expired and swapped in one beat")

	// rejected priority stores nothing and reports level zero
	`AEPQ_ASSERT_IMP(a_range, clk, arst_n, res_valid && (res_status == ST_OUT_OF_RANGE), (res_out_level == '0) && !res_went_expired && !res_banks_swapped, "out of range beat fields wrong")

endmodule

bind active_expired_priority_run_queue_core aepq_checker u_aepq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_status        (res.status),
	.res_out_task      (res.out_task),
	.res_out_level     (res.out_level),
	.res_went_expired  (res.went_expired),
	.res_banks_swapped (res.banks_swapped)
);
`default_nettype wire
